// ===== rtl/core/adcms_pkg.sv =====
// Shared widths, payload types and register indexes of the ADC averaging servo/PWM unit.
package adcms_pkg;

    localparam int AVG_DEPTH      = 10;
    localparam int ADC_FULL_SCALE = 1023;
    localparam int SAMPLE_BITS    = 10;
    localparam int DUTY_FULL      = 100;
    localparam int ANGLE_FULL     = 180;

    localparam int SCALE_BITS    = 8;
    localparam int TICK_BITS     = 16;
    localparam int SET_BITS      = 9;
    localparam int MAG_BITS      = 8;
    localparam int CFG_COUNT     = 7;
    localparam int CFG_IDX_BITS  = $clog2(CFG_COUNT);
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SAMPLE_BITS-1:0]   t_sample;
    typedef logic signed [SET_BITS-1:0] t_setting;
    typedef logic [MAG_BITS-1:0]      t_mag;
    typedef logic [TICK_BITS-1:0]     t_ticks;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_SPEED_SCALE  = CFG_IDX_BITS'(0);
    localparam t_cfg_idx CFG_ANGLE_SCALE  = CFG_IDX_BITS'(1);
    localparam t_cfg_idx CFG_SPEED_OFFSET = CFG_IDX_BITS'(2);
    localparam t_cfg_idx CFG_ANGLE_OFFSET = CFG_IDX_BITS'(3);
    localparam t_cfg_idx CFG_MOTOR_PERIOD = CFG_IDX_BITS'(4);
    localparam t_cfg_idx CFG_SERVO_MIN    = CFG_IDX_BITS'(5);
    localparam t_cfg_idx CFG_SERVO_SPAN   = CFG_IDX_BITS'(6);

endpackage

// ===== rtl/core/adcms_if.sv =====
// Request channels of the ADC averaging servo/PWM unit: samples, results, register writes.
interface adcms_in_if;
    logic               valid;
    logic               ready;
    adcms_pkg::t_sample speed_sample;
    adcms_pkg::t_sample angle_sample;

    modport source (output valid, output speed_sample, output angle_sample, input ready);
    modport sink   (input valid, input speed_sample, input angle_sample, output ready);
endinterface

interface adcms_out_if;
    logic                valid;
    logic                ready;
    adcms_pkg::t_setting speed_setting;
    adcms_pkg::t_mag     abs_speed;
    adcms_pkg::t_setting angle_setting;
    adcms_pkg::t_mag     abs_angle;
    logic                drive_forward;
    logic                drive_reverse;
    adcms_pkg::t_ticks   motor_compare;
    adcms_pkg::t_ticks   servo_compare;

    modport source (
        output valid, output speed_setting, output abs_speed, output angle_setting,
        output abs_angle, output drive_forward, output drive_reverse,
        output motor_compare, output servo_compare, input ready
    );
    modport sink (
        input valid, input speed_setting, input abs_speed, input angle_setting,
        input abs_angle, input drive_forward, input drive_reverse,
        input motor_compare, input servo_compare, output ready
    );
endinterface

interface adcms_cfg_if;
    logic                 valid;
    logic                 ready;
    adcms_pkg::t_cfg_idx  index;
    adcms_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/adc_average_motor_servo_pwm_unit.sv =====
// Moving-average ADC pair to motor PWM compare and servo pulse width, top level.
//
// Each request carries one speed and one angle ADC sample. Both samples go into a
// sliding window of AVG_DEPTH entries held in one synchronous memory (zero after
// reset, so early averages are pulled toward zero until the window fills). The
// averages are scaled with round-half-up, offsets are subtracted, and the H-bridge
// direction bits, motor compare and servo pulse width are derived, the last two
// saturated to 16 bits. The unit works on one request at a time: the next request
// is taken only after the sequence of one memory read, one read-modify-write of
// the window and running sums, and three constant divisions done as reciprocal
// multiply plus correction, with a scale multiply, an offset stage and a compare
// multiply between them. The last step waits while the output register is full;
// the result is then loaded into that output register, so the next request is
// taken while it waits. Register writes are always ready.
module adc_average_motor_servo_pwm_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    adcms_in_if.sink      i_in,
    adcms_out_if.source   o_out,
    adcms_cfg_if.sink     i_cfg
);
    import adcms_pkg::*;

    localparam int SLOT_BITS  = $clog2(AVG_DEPTH);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(AVG_DEPTH);
    localparam int SUM_MAX    = (2**SAMPLE_BITS - 1) * AVG_DEPTH;
    localparam int SNUM_BITS  = $clog2((2**SAMPLE_BITS - 1) * (2**SCALE_BITS - 1)
                                       + ADC_FULL_SCALE / 2 + 1);
    localparam int ONUM_BITS  = MAG_BITS + TICK_BITS;
    localparam int MEM_BITS   = 2 * SAMPLE_BITS;

    // Reciprocals floor(2^W / D); the estimate is low by at most one.
    localparam logic [SUM_BITS:0]  AVG_RECIP   = (SUM_BITS+1)'((2**SUM_BITS) / AVG_DEPTH);
    localparam logic [SNUM_BITS:0] SCL_RECIP   =
        (SNUM_BITS+1)'((2**SNUM_BITS) / ADC_FULL_SCALE);
    localparam logic [ONUM_BITS:0] DUTY_RECIP  = (ONUM_BITS+1)'((2**ONUM_BITS) / DUTY_FULL);
    localparam logic [ONUM_BITS:0] ANGLE_RECIP = (ONUM_BITS+1)'((2**ONUM_BITS) / ANGLE_FULL);

    localparam logic [SCALE_BITS-1:0] RST_SPEED_SCALE  = SCALE_BITS'(198);
    localparam logic [SCALE_BITS-1:0] RST_ANGLE_SCALE  = SCALE_BITS'(180);
    localparam logic [SCALE_BITS-1:0] RST_SPEED_OFFSET = SCALE_BITS'(99);
    localparam logic [SCALE_BITS-1:0] RST_ANGLE_OFFSET = SCALE_BITS'(90);
    localparam t_ticks RST_MOTOR_PERIOD = TICK_BITS'(1999);
    localparam t_ticks RST_SERVO_MIN    = TICK_BITS'(750);
    localparam t_ticks RST_SERVO_SPAN   = TICK_BITS'(1500);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_AVG_EST, S_AVG_FIX, S_SCL_MUL, S_SCL_EST, S_SCL_FIX,
        S_SET, S_OUT_MUL, S_OUT_EST, S_OUT_FIX
    } t_state;

    // configuration
    logic [SCALE_BITS-1:0] r_speed_scale, r_angle_scale, r_speed_offset, r_angle_offset;
    t_ticks                r_motor_period, r_servo_min, r_servo_span;

    // window memory and its bookkeeping
    logic [MEM_BITS-1:0]   r_mem [AVG_DEPTH];
    logic [MEM_BITS-1:0]   r_rd;
    logic [AVG_DEPTH-1:0]  r_valid;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [SUM_BITS-1:0]   r_sum_s, r_sum_a;
    t_sample               r_new_s, r_new_a;

    t_state                r_state;

    // datapath
    logic [SUM_BITS-1:0]   r_qe_s, r_qe_a;
    t_sample               r_avg_s, r_avg_a;
    logic [SNUM_BITS-1:0]  r_snum_s, r_snum_a, r_sqe_s, r_sq_s, r_sqe_a, r_sq_a;
    t_setting              r_speed, r_angle;
    t_mag                  r_abs_s, r_sc_a;
    logic [ONUM_BITS-1:0]  r_onum_m, r_onum_v, r_oqe_m, r_oqe_v;

    // output register
    logic                  r_out_valid;
    t_setting              r_o_speed, r_o_angle;
    t_mag                  r_o_abs_speed, r_o_abs_angle;
    logic                  r_o_fwd, r_o_rev;
    t_ticks                r_o_motor, r_o_servo;

    logic                  w_in_acc, w_out_acc, w_out_load;
    logic [SAMPLE_BITS-1:0] w_old_s, w_old_a;
    logic [2*SUM_BITS:0]   w_ap_s, w_ap_a;
    logic [SUM_BITS-1:0]   w_ar_s, w_ar_a;
    logic [2*SNUM_BITS:0]  w_sp_s, w_sp_a;
    logic [SNUM_BITS-1:0]  w_sr_s, w_sr_a;
    t_mag                  w_sc_s, w_sc_a;
    t_setting              w_speed, w_angle;
    logic [2*ONUM_BITS:0]  w_op_m, w_op_v;
    logic [ONUM_BITS-1:0]  w_or_m, w_or_v, w_oq_m, w_oq_v;
    logic [ONUM_BITS:0]    w_servo_sum;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = r_out_valid && o_out.ready;
    assign w_out_load = (r_state == S_OUT_FIX) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.speed_setting = r_o_speed;
    assign o_out.abs_speed     = r_o_abs_speed;
    assign o_out.angle_setting = r_o_angle;
    assign o_out.abs_angle     = r_o_abs_angle;
    assign o_out.drive_forward = r_o_fwd;
    assign o_out.drive_reverse = r_o_rev;
    assign o_out.motor_compare = r_o_motor;
    assign o_out.servo_compare = r_o_servo;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale  <= RST_SPEED_SCALE;
            r_angle_scale  <= RST_ANGLE_SCALE;
            r_speed_offset <= RST_SPEED_OFFSET;
            r_angle_offset <= RST_ANGLE_OFFSET;
            r_motor_period <= RST_MOTOR_PERIOD;
            r_servo_min    <= RST_SERVO_MIN;
            r_servo_span   <= RST_SERVO_SPAN;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SPEED_SCALE:  r_speed_scale  <= i_cfg.data[SCALE_BITS-1:0];
                CFG_ANGLE_SCALE:  r_angle_scale  <= i_cfg.data[SCALE_BITS-1:0];
                CFG_SPEED_OFFSET: r_speed_offset <= i_cfg.data[SCALE_BITS-1:0];
                CFG_ANGLE_OFFSET: r_angle_offset <= i_cfg.data[SCALE_BITS-1:0];
                CFG_MOTOR_PERIOD: r_motor_period <= i_cfg.data[TICK_BITS-1:0];
                CFG_SERVO_MIN:    r_servo_min    <= i_cfg.data[TICK_BITS-1:0];
                CFG_SERVO_SPAN:   r_servo_span   <= i_cfg.data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Window memory: read the oldest pair on accept, overwrite it in the next cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd <= r_mem[r_slot];
        end
        if (r_state == S_SUM) begin
            r_mem[r_slot] <= {r_new_a, r_new_s};
        end
    end

    // Entries never written read as zero
    assign w_old_s = r_valid[r_slot] ? r_rd[SAMPLE_BITS-1:0] : '0;
    assign w_old_a = r_valid[r_slot] ? r_rd[MEM_BITS-1:SAMPLE_BITS] : '0;

    always_comb begin
        w_ap_s = (2*SUM_BITS+1)'(r_sum_s) * (2*SUM_BITS+1)'(AVG_RECIP);
        w_ap_a = (2*SUM_BITS+1)'(r_sum_a) * (2*SUM_BITS+1)'(AVG_RECIP);
        w_ar_s = r_sum_s - SUM_BITS'(r_qe_s * SUM_BITS'(AVG_DEPTH));
        w_ar_a = r_sum_a - SUM_BITS'(r_qe_a * SUM_BITS'(AVG_DEPTH));

        w_sp_s = (2*SNUM_BITS+1)'(r_snum_s) * (2*SNUM_BITS+1)'(SCL_RECIP);
        w_sp_a = (2*SNUM_BITS+1)'(r_snum_a) * (2*SNUM_BITS+1)'(SCL_RECIP);
        w_sr_s = r_snum_s - SNUM_BITS'(r_sqe_s * SNUM_BITS'(ADC_FULL_SCALE));
        w_sr_a = r_snum_a - SNUM_BITS'(r_sqe_a * SNUM_BITS'(ADC_FULL_SCALE));

        // saturate the scaled value, then remove the offsets
        w_sc_s  = (r_sq_s > SNUM_BITS'(2**MAG_BITS - 1)) ? '1 : r_sq_s[MAG_BITS-1:0];
        w_sc_a  = (r_sq_a > SNUM_BITS'(2**MAG_BITS - 1)) ? '1 : r_sq_a[MAG_BITS-1:0];
        w_speed = $signed({1'b0, w_sc_s}) - $signed({1'b0, r_speed_offset});
        w_angle = $signed({1'b0, w_sc_a}) - $signed({1'b0, r_angle_offset});

        w_op_m = (2*ONUM_BITS+1)'(r_onum_m) * (2*ONUM_BITS+1)'(DUTY_RECIP);
        w_op_v = (2*ONUM_BITS+1)'(r_onum_v) * (2*ONUM_BITS+1)'(ANGLE_RECIP);
        w_or_m = r_onum_m - ONUM_BITS'(r_oqe_m * ONUM_BITS'(DUTY_FULL));
        w_or_v = r_onum_v - ONUM_BITS'(r_oqe_v * ONUM_BITS'(ANGLE_FULL));
        w_oq_m = (w_or_m >= ONUM_BITS'(DUTY_FULL)) ? r_oqe_m + 1'b1 : r_oqe_m;
        w_oq_v = (w_or_v >= ONUM_BITS'(ANGLE_FULL)) ? r_oqe_v + 1'b1 : r_oqe_v;
        w_servo_sum = {1'b0, w_oq_v} + (ONUM_BITS+1)'(r_servo_min);
    end

    // Sequencer, window bookkeeping, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_valid     <= '0;
            r_sum_s     <= '0;
            r_sum_a     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_new_s <= i_in.speed_sample;
                        r_new_a <= i_in.angle_sample;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum_s         <= r_sum_s - SUM_BITS'(w_old_s) + SUM_BITS'(r_new_s);
                    r_sum_a         <= r_sum_a - SUM_BITS'(w_old_a) + SUM_BITS'(r_new_a);
                    r_valid[r_slot] <= 1'b1;
                    r_slot          <= (r_slot == SLOT_BITS'(AVG_DEPTH - 1)) ? '0
                                                                             : r_slot + 1'b1;
                    r_state         <= S_AVG_EST;
                end
                S_AVG_EST: begin
                    r_qe_s  <= w_ap_s[2*SUM_BITS-1:SUM_BITS];
                    r_qe_a  <= w_ap_a[2*SUM_BITS-1:SUM_BITS];
                    r_state <= S_AVG_FIX;
                end
                S_AVG_FIX: begin
                    r_avg_s <= SAMPLE_BITS'((w_ar_s >= SUM_BITS'(AVG_DEPTH)) ? r_qe_s + 1'b1
                                                                            : r_qe_s);
                    r_avg_a <= SAMPLE_BITS'((w_ar_a >= SUM_BITS'(AVG_DEPTH)) ? r_qe_a + 1'b1
                                                                            : r_qe_a);
                    r_state <= S_SCL_MUL;
                end
                S_SCL_MUL: begin
                    // add half the full scale to round to nearest
                    r_snum_s <= SNUM_BITS'(SNUM_BITS'(r_avg_s) * SNUM_BITS'(r_speed_scale))
                                + SNUM_BITS'(ADC_FULL_SCALE / 2);
                    r_snum_a <= SNUM_BITS'(SNUM_BITS'(r_avg_a) * SNUM_BITS'(r_angle_scale))
                                + SNUM_BITS'(ADC_FULL_SCALE / 2);
                    r_state  <= S_SCL_EST;
                end
                S_SCL_EST: begin
                    r_sqe_s <= w_sp_s[2*SNUM_BITS-1:SNUM_BITS];
                    r_sqe_a <= w_sp_a[2*SNUM_BITS-1:SNUM_BITS];
                    r_state <= S_SCL_FIX;
                end
                S_SCL_FIX: begin
                    r_sq_s  <= (w_sr_s >= SNUM_BITS'(ADC_FULL_SCALE)) ? r_sqe_s + 1'b1 : r_sqe_s;
                    r_sq_a  <= (w_sr_a >= SNUM_BITS'(ADC_FULL_SCALE)) ? r_sqe_a + 1'b1 : r_sqe_a;
                    r_state <= S_SET;
                end
                S_SET: begin
                    r_speed <= w_speed;
                    r_angle <= w_angle;
                    r_abs_s <= w_speed[SET_BITS-1] ? MAG_BITS'(-w_speed) : MAG_BITS'(w_speed);
                    r_sc_a  <= w_sc_a;
                    r_state <= S_OUT_MUL;
                end
                S_OUT_MUL: begin
                    r_onum_m <= ONUM_BITS'(r_abs_s) * ONUM_BITS'(r_motor_period);
                    r_onum_v <= ONUM_BITS'(r_sc_a) * ONUM_BITS'(r_servo_span);
                    r_state  <= S_OUT_EST;
                end
                S_OUT_EST: begin
                    r_oqe_m <= w_op_m[2*ONUM_BITS-1:ONUM_BITS];
                    r_oqe_v <= w_op_v[2*ONUM_BITS-1:ONUM_BITS];
                    r_state <= S_OUT_FIX;
                end
                S_OUT_FIX: begin
                    // hold until the output register is free
                    if (w_out_load) begin
                        r_o_speed     <= r_speed;
                        r_o_abs_speed <= r_abs_s;
                        r_o_angle     <= r_angle;
                        r_o_abs_angle <= r_sc_a;
                        r_o_fwd       <= !r_speed[SET_BITS-1] && (r_speed != '0);
                        r_o_rev       <= r_speed[SET_BITS-1];
                        r_o_motor     <= (w_oq_m > ONUM_BITS'(2**TICK_BITS - 1)) ? '1
                                         : w_oq_m[TICK_BITS-1:0];
                        r_o_servo     <= (w_servo_sum > (ONUM_BITS+1)'(2**TICK_BITS - 1)) ? '1
                                         : w_servo_sum[TICK_BITS-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_s <= SUM_BITS'(SUM_MAX)) && (r_sum_a <= SUM_BITS'(SUM_MAX)))
        else $error("window sum beyond full window");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_BITS'(AVG_DEPTH - 1))
        else $error("window slot out of range");

    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT_FIX))
        else $error("result raised outside the final step");

    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_fwd && r_o_rev))
        else $error("both H-bridge inputs driven");

    a_abs_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_speed[SET_BITS-1] |-> r_o_abs_speed == MAG_BITS'(-r_o_speed))
        else $error("speed magnitude mismatch");
`endif

endmodule
